/* rtl/lowest_pc_warp_issue_scheduler_unit_defines.svh */
// Assertion macros shared by the scheduler checker.
`ifndef LOWEST_PC_WARP_ISSUE_SCHEDULER_UNIT_DEFINES_SVH
`define LOWEST_PC_WARP_ISSUE_SCHEDULER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LPWS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LPWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lpws_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lpws_pkg;

    // Default sizing
    localparam int LANES_DEF    = 32;
    localparam int PC_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int WORD_W = 32;
    localparam int TC_W   = 6;
    localparam int KIND_W = 2;
    localparam int SIZE_W = 5;
    localparam int CFG_AW = 4;

    // Register reset values
    localparam logic [WORD_W-1:0] CODE_BASE_RST    = 32'h0000_1000;
    localparam logic [TC_W-1:0]   THREAD_COUNT_RST = 6'd32;
    localparam logic [WORD_W-1:0] CODE_SIZE_RST    = 32'd65536;
    localparam logic [WORD_W-1:0] MAX_STEPS_RST    = 32'd100000;

    // Register map (word index)
    typedef enum logic [1:0] {
        REG_CODE_BASE    = 2'd0,
        REG_THREAD_COUNT = 2'd1,
        REG_CODE_SIZE    = 2'd2,
        REG_MAX_STEPS    = 2'd3
    } t_reg_idx;

    // Request modes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_RESOLVE = 1'b1;

    // Outcome kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ADVANCE = 2'd0,
        KIND_BRANCH  = 2'd1,
        KIND_PRED    = 2'd2,
        KIND_EXIT    = 2'd3
    } t_kind;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [WORD_W-1:0] code_base;
        logic [TC_W-1:0]   thread_count;
        logic [WORD_W-1:0] code_size;
        logic [WORD_W-1:0] max_steps;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic update;   // apply the accepted request to lane state
        logic load;     // copy active lanes into the min tree
        logic reduce;   // one pairwise min level
        logic finish;   // form the issue group and the result
    } t_cmd;

    // Controller state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

endpackage
`default_nettype wire

/* rtl/lpws_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpws_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lpws_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lpws_pkg::t_cfg             o_cfg
);
    import lpws_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_base    <= CODE_BASE_RST;
            r_cfg.thread_count <= THREAD_COUNT_RST;
            r_cfg.code_size    <= CODE_SIZE_RST;
            r_cfg.max_steps    <= MAX_STEPS_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_CODE_BASE:    r_cfg.code_base    <= pwdata;
                REG_THREAD_COUNT: r_cfg.thread_count <= pwdata[TC_W-1:0];
                REG_CODE_SIZE:    r_cfg.code_size    <= pwdata;
                REG_MAX_STEPS:    r_cfg.max_steps    <= pwdata;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_idx)
            REG_CODE_BASE:    prdata = r_cfg.code_base;
            REG_THREAD_COUNT: prdata = 32'(r_cfg.thread_count);
            REG_CODE_SIZE:    prdata = r_cfg.code_size;
            REG_MAX_STEPS:    prdata = r_cfg.max_steps;
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/lpws_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpws_ctrl #(
    parameter int LANES = lpws_pkg::LANES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output lpws_pkg::t_cmd o_cmd
);
    import lpws_pkg::*;

    localparam int LEVELS = $clog2(LANES);
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    t_state             r_state, n_state;
    logic [LVL_W-1:0]   r_level, n_level;
    logic               w_last;

    assign o_busy = (r_state != ST_IDLE);
    assign w_last = (r_level == LVL_W'(LEVELS - 1));

    // Commands decoded from state
    always_comb begin
        o_cmd        = '0;
        o_cmd.update = (r_state == ST_IDLE) && i_start;
        o_cmd.load   = (r_state == ST_LOAD);
        o_cmd.reduce = (r_state == ST_REDUCE);
        o_cmd.finish = (r_state == ST_FINISH);
    end

    // Next state and level count
    always_comb begin
        n_state = r_state;
        n_level = r_level;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_level = '0;
                n_state = ST_REDUCE;
            end
            ST_REDUCE: begin
                n_level = r_level + 1'b1;
                if (w_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_level <= '0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

endmodule
`default_nettype wire

/* rtl/lpws_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpws_dpath #(
    parameter int LANES    = lpws_pkg::LANES_DEF,
    parameter int PC_WIDTH = lpws_pkg::PC_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpws_pkg::t_cmd              i_cmd,
    input  lpws_pkg::t_cfg              i_cfg,
    input  logic                        i_mode,
    input  logic [lpws_pkg::KIND_W-1:0] i_outcome_kind,
    input  logic [31:0]                 i_branch_target,
    input  logic [31:0]                 i_taken_lanes,
    input  logic [lpws_pkg::SIZE_W-1:0] i_instr_bytes,
    output logic                        o_valid,
    output logic [31:0]                 o_issue_pc,
    output logic [31:0]                 o_issue_mask,
    output logic [31:0]                 o_code_offset,
    output logic                        o_all_exited,
    output logic                        o_outside_kernel,
    output logic                        o_step_limit_hit
);
    import lpws_pkg::*;

    localparam int LEVELS = $clog2(LANES);
    localparam int SLOTS  = 2 ** LEVELS;

    // Lane state
    logic [PC_WIDTH-1:0] r_lane_pc [LANES];
    logic [PC_WIDTH-1:0] n_lane_pc [LANES];
    logic [LANES-1:0]    r_active, n_active;
    logic [PC_WIDTH-1:0] r_group_pc;
    logic [LANES-1:0]    r_group_mask;
    logic [WORD_W-1:0]   r_step, n_step;

    // Min tree slots
    logic [PC_WIDTH-1:0] r_cand_pc  [SLOTS];
    logic                r_cand_vld [SLOTS];

    // Result registers
    logic                r_valid;
    logic [31:0]         r_issue_pc, r_issue_mask, r_code_offset;
    logic                r_all_exited, r_outside, r_limit;

    logic [PC_WIDTH-1:0] w_base_pc, w_target, w_size, w_seq_pc;
    logic [LANES-1:0]    w_taken, w_start_mask, w_hit;
    t_kind               w_kind;
    logic [PC_WIDTH-1:0] w_best, w_off;
    logic                w_any, w_outside;
    logic [WORD_W-1:0]   w_step_inc;

    assign w_base_pc = PC_WIDTH'(i_cfg.code_base);
    assign w_target  = PC_WIDTH'(i_branch_target);
    assign w_size    = PC_WIDTH'(i_instr_bytes);
    assign w_taken   = LANES'(i_taken_lanes);
    assign w_kind    = t_kind'(i_outcome_kind);
    assign w_seq_pc  = r_group_pc + w_size;

    // Lanes below thread_count start active
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_start_mask[l] = (7'(l) < {1'b0, i_cfg.thread_count});
        end
    end

    // Apply an accepted request to lane PCs, active mask and step count; count each issued group
    always_comb begin
        n_active = r_active;
        n_step   = r_step;
        for (int l = 0; l < LANES; l++) begin
            n_lane_pc[l] = r_lane_pc[l];
        end
        if (i_cmd.update) begin
            if (i_mode == MODE_START) begin
                n_active = w_start_mask;
                n_step   = '0;
                for (int l = 0; l < LANES; l++) begin
                    n_lane_pc[l] = w_base_pc;
                end
            end else if (w_kind == KIND_EXIT) begin
                n_active = r_active & ~r_group_mask;
            end else begin
                for (int l = 0; l < LANES; l++) begin
                    if (r_group_mask[l]) begin
                        case (w_kind)
                            KIND_ADVANCE: n_lane_pc[l] = r_lane_pc[l] + w_size;
                            KIND_BRANCH:  n_lane_pc[l] = w_target;
                            KIND_PRED:    n_lane_pc[l] = w_taken[l] ? w_target : w_seq_pc;
                            default:      n_lane_pc[l] = r_lane_pc[l];
                        endcase
                    end
                end
            end
        end else if (i_cmd.finish && w_any) begin
            n_step = w_step_inc;
        end
    end

    // Group forming from the tree root
    assign w_best     = r_cand_pc[0];
    assign w_any      = r_cand_vld[0];
    assign w_off      = w_best - w_base_pc;
    assign w_outside  = (64'(w_off) >= 64'(i_cfg.code_size));
    assign w_step_inc = (r_step == '1) ? r_step : r_step + 1'b1;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_hit[l] = r_active[l] && (r_lane_pc[l] == w_best);
        end
    end

    // Lane PC storage
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_lane_pc[l] <= n_lane_pc[l];
        end
    end

    // Min tree: load, then one pairwise level per cycle into the low half
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (s < LANES) begin
                    r_cand_pc[s]  <= r_lane_pc[s];
                    r_cand_vld[s] <= r_active[s];
                end else begin
                    r_cand_pc[s]  <= '0;
                    r_cand_vld[s] <= 1'b0;
                end
            end
        end else if (i_cmd.reduce) begin
            for (int s = 0; s < SLOTS / 2; s++) begin
                if (r_cand_vld[2*s] &&
                    (!r_cand_vld[2*s+1] || r_cand_pc[2*s] <= r_cand_pc[2*s+1])) begin
                    r_cand_pc[s]  <= r_cand_pc[2*s];
                    r_cand_vld[s] <= 1'b1;
                end else begin
                    r_cand_pc[s]  <= r_cand_pc[2*s+1];
                    r_cand_vld[s] <= r_cand_vld[2*s+1];
                end
            end
        end
    end

    // Control state of the warp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_step       <= '0;
            r_group_pc   <= '0;
            r_group_mask <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_active <= n_active;
            r_step   <= n_step;
            r_valid  <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_group_pc   <= w_any ? w_best : '0;
                r_group_mask <= w_any ? w_hit : '0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_issue_pc    <= w_any ? 32'(w_best) : '0;
            r_issue_mask  <= w_any ? 32'(w_hit) : '0;
            r_code_offset <= w_any ? 32'(w_off) : '0;
            r_all_exited  <= !w_any;
            r_outside     <= w_any && w_outside;
            r_limit       <= w_any && (w_step_inc > i_cfg.max_steps);
        end
    end

    assign o_valid          = r_valid;
    assign o_issue_pc       = r_issue_pc;
    assign o_issue_mask     = r_issue_mask;
    assign o_code_offset    = r_code_offset;
    assign o_all_exited     = r_all_exited;
    assign o_outside_kernel = r_outside;
    assign o_step_limit_hit = r_limit;

endmodule
`default_nettype wire

/* rtl/lowest_pc_warp_issue_scheduler_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Lowest-PC warp issue scheduler.
// Requests come in on start/busy: a request is taken at a clock edge where
// start is high and busy is low. i_mode selects a warp start (lane PCs loaded
// from code_base, lanes below thread_count active) or a resolve that applies
// i_outcome_kind to the group issued last (advance, branch, predicated branch,
// exit). Each request yields exactly one result, shown for one cycle with
// o_valid high; the receiver cannot stall it.
// Timing: after the accepting edge the controller steps through LOAD (the
// min tree loads), REDUCE (one pairwise min level per cycle) and FINISH
// (issue mask and flags formed). o_valid is registered from FINISH and busy
// falls in the same cycle as o_valid rises, so a new request is taken only
// once the previous result is out. Registers sit on an APB-style port
// (code_base, thread_count, code_size, max_steps at byte offsets 0, 4, 8, 12).
// The user must write them only while idle; the block does not enforce this.
// Reset (synchronous, active low) restores register defaults, clears the
// active mask, group and step count, and returns the controller to idle.
module lowest_pc_warp_issue_scheduler_unit #(
    parameter int LANES    = lpws_pkg::LANES_DEF,
    parameter int PC_WIDTH = lpws_pkg::PC_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_mode,
    input  logic [lpws_pkg::KIND_W-1:0] i_outcome_kind,
    input  logic [31:0]                 i_branch_target,
    input  logic [31:0]                 i_taken_lanes,
    input  logic [lpws_pkg::SIZE_W-1:0] i_instr_bytes,
    output logic                        o_valid,
    output logic [31:0]                 o_issue_pc,
    output logic [31:0]                 o_issue_mask,
    output logic [31:0]                 o_code_offset,
    output logic                        o_all_exited,
    output logic                        o_outside_kernel,
    output logic                        o_step_limit_hit,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpws_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lpws_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;

    lpws_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lpws_ctrl #(
        .LANES (LANES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    lpws_dpath #(
        .LANES    (LANES),
        .PC_WIDTH (PC_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg            (w_cfg),
        .i_mode           (i_mode),
        .i_outcome_kind   (i_outcome_kind),
        .i_branch_target  (i_branch_target),
        .i_taken_lanes    (i_taken_lanes),
        .i_instr_bytes    (i_instr_bytes),
        .o_valid          (o_valid),
        .o_issue_pc       (o_issue_pc),
        .o_issue_mask     (o_issue_mask),
        .o_code_offset    (o_code_offset),
        .o_all_exited     (o_all_exited),
        .o_outside_kernel (o_outside_kernel),
        .o_step_limit_hit (o_step_limit_hit)
    );

endmodule
`default_nettype wire

/* rtl/lpws_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "lowest_pc_warp_issue_scheduler_unit_defines.svh"
module lpws_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_valid,
    input wire [31:0] o_issue_pc,
    input wire [31:0] o_issue_mask,
    input wire        o_all_exited
);

    // An accepted request keeps the block busy in the next cycle
    `LPWS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after request")

    // A result only appears once the block is free again
    `LPWS_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while busy")

    // One result per request: the result strobe is never held high
    `LPWS_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held")

    // An exited warp issues an empty group at PC zero
    `LPWS_ASSERT_SAME(a_exit_empty, i_clk, i_rst_n, o_valid && o_all_exited, (o_issue_mask == 32'd0) && (o_issue_pc == 32'd0), "exited warp issued lanes")

    // A live warp issues at least one lane
    `LPWS_ASSERT_SAME(a_live_nonempty, i_clk, i_rst_n, o_valid && !o_all_exited, o_issue_mask != 32'd0, "live warp issued no lane")

endmodule

bind lowest_pc_warp_issue_scheduler_unit lpws_checker u_lpws_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_issue_pc   (o_issue_pc),
    .o_issue_mask (o_issue_mask),
    .o_all_exited (o_all_exited)
);
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
    import lpws_pkg::*;

    localparam int LATENCY        = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    // One scheduler request as driven on the input ports
    typedef struct packed {
        logic        mode;
        t_kind       kind;
        logic [31:0] target;
        logic [31:0] taken;
        logic [4:0]  bytes;
    } t_sched_req;

    // One issue group as seen on the result ports
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] mask;
        logic [31:0] offset;
        logic        all_exited;
        logic        outside;
        logic        step_hit;
    } t_issue_group;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_mode;
    t_kind       i_outcome_kind;
    logic [31:0] i_branch_target;
    logic [31:0] i_taken_lanes;
    logic [4:0]  i_instr_bytes;
    logic        o_valid;
    logic [31:0] o_issue_pc;
    logic [31:0] o_issue_mask;
    logic [31:0] o_code_offset;
    logic        o_all_exited;
    logic        o_outside_kernel;
    logic        o_step_limit_hit;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the warp state and registers
    logic [31:0] lane_pc_mirror [32];
    logic [31:0] active_mirror;
    logic [31:0] group_pc_mirror;
    logic [31:0] group_mask_mirror;
    logic [31:0] groups_issued;
    logic [31:0] cfg_code_base;
    logic [5:0]  cfg_thread_count;
    logic [31:0] cfg_code_size;
    logic [31:0] cfg_max_steps;

    t_issue_group pending_groups[$];
    int           errors;
    int           idle_cycles;
    bit           no_idle;

    lowest_pc_warp_issue_scheduler_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_outcome_kind   (i_outcome_kind),
        .i_branch_target  (i_branch_target),
        .i_taken_lanes    (i_taken_lanes),
        .i_instr_bytes    (i_instr_bytes),
        .o_valid          (o_valid),
        .o_issue_pc       (o_issue_pc),
        .o_issue_mask     (o_issue_mask),
        .o_code_offset    (o_code_offset),
        .o_all_exited     (o_all_exited),
        .o_outside_kernel (o_outside_kernel),
        .o_step_limit_hit (o_step_limit_hit),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one request to the mirror and form the group it issues
    function automatic t_issue_group next_issue_group(input t_sched_req req);
        t_issue_group g;
        logic [31:0]  best;
        logic [63:0]  fill;
        if (req.mode == MODE_START) begin
            for (int l = 0; l < 32; l++) lane_pc_mirror[l] = cfg_code_base;
            fill = (64'd1 << cfg_thread_count) - 64'd1;
            active_mirror = (cfg_thread_count >= 6'd32) ? 32'hFFFF_FFFF : fill[31:0];
            groups_issued = '0;
        end else if (req.kind == KIND_EXIT) begin
            active_mirror &= ~group_mask_mirror;
        end else begin
            for (int l = 0; l < 32; l++) begin
                if (group_mask_mirror[l]) begin
                    case (req.kind)
                        KIND_ADVANCE: lane_pc_mirror[l] = lane_pc_mirror[l] + req.bytes;
                        KIND_BRANCH:  lane_pc_mirror[l] = req.target;
                        KIND_PRED:    lane_pc_mirror[l] = req.taken[l] ? req.target
                                                          : group_pc_mirror + req.bytes;
                        default:      ;
                    endcase
                end
            end
        end
        g = '0;
        // Empty warp: report all exited and drop the group
        if (active_mirror == '0) begin
            group_pc_mirror   = '0;
            group_mask_mirror = '0;
            g.all_exited      = 1'b1;
            return g;
        end
        best = 32'hFFFF_FFFF;
        for (int l = 0; l < 32; l++)
            if (active_mirror[l] && lane_pc_mirror[l] < best) best = lane_pc_mirror[l];
        for (int l = 0; l < 32; l++)
            g.mask[l] = active_mirror[l] && (lane_pc_mirror[l] == best);
        group_pc_mirror   = best;
        group_mask_mirror = g.mask;
        if (groups_issued != 32'hFFFF_FFFF) groups_issued++;
        g.pc       = best;
        g.offset   = best - cfg_code_base;
        g.outside  = g.offset >= cfg_code_size;
        g.step_hit = groups_issued > cfg_max_steps;
        return g;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Send one request; start stays high if the next one follows at once
    task automatic send_request(input t_sched_req req);
        int gap;
        i_mode          <= req.mode;
        i_outcome_kind  <= req.kind;
        i_branch_target <= req.target;
        i_taken_lanes   <= req.taken;
        i_instr_bytes   <= req.bytes;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_groups.push_back(next_issue_group(req));
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue(input logic mode, input t_kind kind, input logic [31:0] target,
                         input logic [31:0] taken, input logic [4:0] bytes);
        t_sched_req req;
        req = '{mode: mode, kind: kind, target: target, taken: taken, bytes: bytes};
        send_request(req);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_groups.size() != 0) @(posedge i_clk);
    endtask

    // Setup, access, then an idle phase on the bus
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CODE_BASE:    cfg_code_base    = data;
            REG_THREAD_COUNT: cfg_thread_count = data[5:0];
            REG_CODE_SIZE:    cfg_code_size    = data;
            REG_MAX_STEPS:    cfg_max_steps    = data;
            default:          ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic reg_read(input t_reg_idx idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read every register back against the mirror
    task automatic check_registers();
        logic [31:0] rd;
        reg_read(REG_CODE_BASE, rd);
        check_field("code_base", cfg_code_base, rd);
        reg_read(REG_THREAD_COUNT, rd);
        check_field("thread_count", {26'd0, cfg_thread_count}, {26'd0, rd[5:0]});
        reg_read(REG_CODE_SIZE, rd);
        check_field("code_size", cfg_code_size, rd);
        reg_read(REG_MAX_STEPS, rd);
        check_field("max_steps", cfg_max_steps, rd);
    endtask

    task automatic set_config(input logic [31:0] base, input logic [5:0] threads,
                              input logic [31:0] size, input logic [31:0] steps);
        wait_drained();
        reg_write(REG_CODE_BASE, base);
        reg_write(REG_THREAD_COUNT, {26'd0, threads});
        reg_write(REG_CODE_SIZE, size);
        reg_write(REG_MAX_STEPS, steps);
        check_registers();
    endtask

    // Mostly well-formed outcomes around the kernel, a little noise
    function automatic t_sched_req random_resolve();
        t_sched_req req;
        int         r;
        req.mode   = MODE_RESOLVE;
        req.kind   = KIND_ADVANCE;
        req.target = cfg_code_base + 32'(4 * $urandom_range(0, 48));
        req.taken  = $urandom;
        req.bytes  = 5'd2 << $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (r < 3) begin
            req.mode   = 1'($urandom_range(0, 1));
            req.kind   = t_kind'($urandom_range(0, 3));
            req.target = $urandom;
            req.bytes  = 5'($urandom_range(0, 31));
            return req;
        end
        r = $urandom_range(0, 99);
        if (r < 45)      req.kind = KIND_ADVANCE;
        else if (r < 60) req.kind = KIND_BRANCH;
        else if (r < 82) req.kind = KIND_PRED;
        else             req.kind = KIND_EXIT;
        if ($urandom_range(0, 9) < 3) req.bytes = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 9) == 0) req.target = $urandom;
        r = $urandom_range(0, 9);
        if (r < 2)       req.taken = '0;
        else if (r == 2) req.taken = '1;
        return req;
    endfunction

    task automatic test_resolve_before_start();
        issue(MODE_RESOLVE, KIND_ADVANCE, 32'h0000_1000, 32'hFFFF_FFFF, 5'd4);
        issue(MODE_RESOLVE, KIND_EXIT, 32'h0, 32'h0, 5'd0);
    endtask

    task automatic test_register_defaults();
        wait_drained();
        check_registers();
        check_field("code_base reset", CODE_BASE_RST, cfg_code_base);
        check_field("max_steps reset", MAX_STEPS_RST, cfg_max_steps);
    endtask

    // Every outcome kind on one warp: divergence, reconvergence, wrap, exit
    task automatic test_outcome_kinds();
        logic [31:0] b;
        b = cfg_code_base;
        issue(MODE_START, KIND_ADVANCE, 32'h0, 32'h0, 5'd0);
        issue(MODE_RESOLVE, KIND_ADVANCE, 32'h0, 32'h0, 5'd4);
        issue(MODE_RESOLVE, KIND_PRED, b + 32'h40, 32'h0000_FFFF, 5'd4);
        issue(MODE_RESOLVE, KIND_ADVANCE, 32'h0, 32'h0, 5'd31);
        issue(MODE_RESOLVE, KIND_BRANCH, b + 32'h40, 32'h0, 5'd4);
        issue(MODE_RESOLVE, KIND_ADVANCE, 32'h0, 32'h0, 5'd0);
        issue(MODE_RESOLVE, KIND_PRED, b + 32'h100, 32'hFFFF_FFFF, 5'd16);
        issue(MODE_RESOLVE, KIND_PRED, b, 32'h0, 5'd16);
        issue(MODE_RESOLVE, KIND_BRANCH, 32'hFFFF_FFF0, 32'h0, 5'd0);
        issue(MODE_RESOLVE, KIND_ADVANCE, 32'h0, 32'h0, 5'd16);
        issue(MODE_RESOLVE, KIND_PRED, 32'h0000_2000, 32'hAAAA_AAAA, 5'd4);
        issue(MODE_RESOLVE, KIND_EXIT, 32'h0, 32'h0, 5'd4);
        issue(MODE_RESOLVE, KIND_EXIT, 32'h0, 32'h0, 5'd4);
        issue(MODE_RESOLVE, KIND_ADVANCE, 32'h0, 32'h0, 5'd4);
    endtask

    // No threads, a single thread, and counts past the lane count
    task automatic test_thread_count_extremes();
        set_config(32'h0000_1000, 6'd0, 32'd65536, 32'd100000);
        issue(MODE_START, KIND_ADVANCE, 32'h0, 32'h0, 5'd0);
        issue(MODE_RESOLVE, KIND_BRANCH, 32'h0000_1000, 32'h0, 5'd4);
        set_config(32'h0000_1000, 6'd1, 32'd65536, 32'd100000);
        issue(MODE_START, KIND_EXIT, 32'h0, 32'h0, 5'd0);
        issue(MODE_RESOLVE, KIND_PRED, 32'h0000_1100, 32'hFFFF_FFFE, 5'd8);
        set_config(32'h0000_1000, 6'd33, 32'd65536, 32'd100000);
        issue(MODE_START, KIND_ADVANCE, 32'h0, 32'h0, 5'd0);
        set_config(32'h0000_1000, 6'd63, 32'd65536, 32'd100000);
        issue(MODE_START, KIND_ADVANCE, 32'h0, 32'h0, 5'd0);
    endtask

    // Zero limit flags the first group; a small limit flags the third
    task automatic test_step_limit();
        set_config(32'h0000_1000, 6'd32, 32'd65536, 32'd0);
        issue(MODE_START, KIND_ADVANCE, 32'h0, 32'h0, 5'd0);
        set_config(32'h0000_1000, 6'd32, 32'd65536, 32'd2);
        issue(MODE_START, KIND_ADVANCE, 32'h0, 32'h0, 5'd0);
        issue(MODE_RESOLVE, KIND_ADVANCE, 32'h0, 32'h0, 5'd4);
        issue(MODE_RESOLVE, KIND_ADVANCE, 32'h0, 32'h0, 5'd4);
    endtask

    // Code base at the top of the address space: lane PCs wrap through zero
    task automatic test_pc_wrap();
        set_config(32'hFFFF_FFF8, 6'd32, 32'd8, 32'd1);
        issue(MODE_START, KIND_ADVANCE, 32'h0, 32'h0, 5'd0);
        issue(MODE_RESOLVE, KIND_ADVANCE, 32'h0, 32'h0, 5'd8);
    endtask

    // Warp programs with random content under one register setting
    task automatic run_random_phase(input logic [31:0] base, input logic [5:0] threads,
                                    input logic [31:0] size, input logic [31:0] steps,
                                    input int count);
        t_sched_req req;
        int         sent;
        int         plen;
        set_config(base, threads, size, steps);
        sent = 0;
        while (sent < count) begin
            no_idle    = ($urandom_range(0, 5) == 0);
            req        = random_resolve();
            req.mode   = MODE_START;
            send_request(req);
            sent++;
            plen = $urandom_range(8, 80);
            for (int i = 0; i < plen && sent < count; i++) begin
                if (active_mirror == '0 && $urandom_range(0, 3) != 0) break;
                send_request(random_resolve());
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_phases();
        run_random_phase(32'h0000_1000, 6'd32, 32'd65536, 32'd100000, 300);
        run_random_phase(32'hFFFF_FF00, 6'd5, 32'h80, 32'd20, 300);
        run_random_phase(32'h0, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 300);
        run_random_phase($urandom, 6'd1, 32'd0, 32'd1, 250);
        run_random_phase($urandom, 6'($urandom_range(0, 63)), $urandom_range(0, 512),
                         $urandom_range(1, 50), 300);
        run_random_phase(32'h8000_0000, 6'd17, 32'd256, 32'd10, 300);
    endtask

    // Compare each result with the oldest outstanding request
    always @(posedge i_clk) begin
        t_issue_group want;
        if (i_rst_n && o_valid) begin
            if (pending_groups.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, actual pc %h mask %h",
                         $time, o_issue_pc, o_issue_mask);
            end else begin
                want = pending_groups.pop_front();
                check_field("issue_pc", want.pc, o_issue_pc);
                check_field("issue_mask", want.mask, o_issue_mask);
                check_field("code_offset", want.offset, o_code_offset);
                check_field("all_exited", {31'd0, want.all_exited}, {31'd0, o_all_exited});
                check_field("outside_kernel", {31'd0, want.outside}, {31'd0, o_outside_kernel});
                check_field("step_limit_hit", {31'd0, want.step_hit},
                            {31'd0, o_step_limit_hit});
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        errors           = 0;
        idle_cycles      = 0;
        no_idle          = 1'b0;
        active_mirror    = '0;
        group_pc_mirror  = '0;
        group_mask_mirror = '0;
        groups_issued    = '0;
        cfg_code_base    = CODE_BASE_RST;
        cfg_thread_count = THREAD_COUNT_RST;
        cfg_code_size    = CODE_SIZE_RST;
        cfg_max_steps    = MAX_STEPS_RST;
        for (int l = 0; l < 32; l++) lane_pc_mirror[l] = '0;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_mode          <= MODE_START;
        i_outcome_kind  <= KIND_ADVANCE;
        i_branch_target <= '0;
        i_taken_lanes   <= '0;
        i_instr_bytes   <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_resolve_before_start();
        test_register_defaults();
        test_outcome_kinds();
        test_thread_count_extremes();
        test_step_limit();
        test_pc_wrap();
        test_random_phases();

        wait_drained();
        repeat (3 * LATENCY) @(posedge i_clk);
        if (errors == 0 && pending_groups.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
